// ----- src/edd_pkg.sv -----
package edd_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int LW_BITS       = 11;
    localparam int FH_BITS       = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int ERR_BITS      = 16;
    localparam int ACC_BITS      = 24;

    // output queue: one slot for the word on the port, one for the item in
    // the compute stage, one for the item just accepted
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PW    = 2;

    typedef logic signed [ERR_BITS-1:0] t_err;
    typedef logic signed [ACC_BITS-1:0] t_acc;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LINE_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    localparam logic [LW_BITS-1:0] LW_RESET = 11'd640;
    localparam logic [FH_BITS-1:0] FH_RESET = 13'd480;

    localparam t_acc THRESH      = 24'sd2032;   // 127 in 1/16 units
    localparam t_acc WHITE_LEVEL = 24'sd4080;   // 255 in 1/16 units
    localparam t_acc SAT_MAX     = 24'sd32767;
    localparam t_acc SAT_MIN     = -24'sd32768;
    localparam t_acc HALF_UNIT   = 24'sd8;

endpackage

// ----- src/error_diffusion_dither_unit.sv -----
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------
// pixel in  | in        | i_in_valid / o_in_stall   | i_gray_pixel
// dither out| out       | o_out_valid / i_out_stall | o_out_white, o_end_of_row
// config    | in        | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One pixel per clock while the input is not stalled: a transfer reads the line buffer,
// the next cycle computes the bit and writes the buffer back; the right_carry feedback
// sets that rate. The output can transfer once the item has passed the compute stage into
// the output queue. After reset a clearing pass zeroes the line buffer with o_in_stall high;
// config writes are taken during it. Input stalls while the output queue and the compute
// stage hold three items, and for one cycle when a one-pixel row follows a longer row.
module error_diffusion_dither_unit import edd_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // pixel input
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [PIXEL_BITS-1:0]    i_gray_pixel,
    // dithered output
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_out_white,
    output logic                     o_end_of_row,
    // configuration
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    function automatic t_acc rdiv16(input t_acc x);
        rdiv16 = (x + HALF_UNIT) >>> 4;
    endfunction

    function automatic t_err sat16(input t_acc x);
        if (x > SAT_MAX) begin
            sat16 = t_err'(SAT_MAX);
        end else if (x < SAT_MIN) begin
            sat16 = t_err'(SAT_MIN);
        end else begin
            sat16 = x[ERR_BITS-1:0];
        end
    endfunction

    // ---------------- configuration registers ----------------
    logic [LW_BITS-1:0] r_line_width;
    logic [FH_BITS-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[LW_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective limits: zero acts as one, anything above the maximum clamps.
    logic [AW:0] w_eff;
    logic [RW:0] h_eff;

    always_comb begin
        if (r_line_width == '0) begin
            w_eff = (AW+1)'(1);
        end else if (32'(r_line_width) > MAX_WIDTH) begin
            w_eff = (AW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (AW+1)'(r_line_width);
        end
        if (r_frame_height == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(r_frame_height) > MAX_HEIGHT) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(r_frame_height);
        end
    end

    // ---------------- control state ----------------
    logic                  r_clearing;
    logic [AW-1:0]         r_clr_addr;
    logic [AW-1:0]         r_col;
    logic [RW-1:0]         r_row;
    logic                  r_s2_valid;
    logic [PIXEL_BITS-1:0] r_s2_pixel;
    logic [AW-1:0]         r_s2_col;
    logic                  r_s2_last_col;
    logic                  r_s2_last_row;
    logic                  r_fwd_hit;
    t_err                  r_fwd_data;
    logic                  r_pend_valid;
    logic [AW-1:0]         r_pend_addr;
    t_err                  r_pend_data;
    t_err                  r_right_carry;
    t_err                  r_pbl;
    t_err                  r_pb;

    logic [OUTQ_PW-1:0]    r_count;
    logic [OUTQ_PW-1:0]    r_wr_ptr;
    logic [OUTQ_PW-1:0]    r_rd_ptr;
    logic                  r_q_white [OUTQ_DEPTH];
    logic                  r_q_eor   [OUTQ_DEPTH];

    logic in_acc;
    logic out_acc;
    logic last_col_in;
    logic last_row_in;

    // Stall while clearing, or when the queue could not hold one more item.
    // Also hold a one-pixel row for a cycle while a longer row still owes its
    // deferred write, so that both writes of the line buffer land.
    assign o_in_stall = r_clearing ||
        ((3'(r_count) + 3'(r_s2_valid)) >= 3'(OUTQ_DEPTH)) ||
        (r_s2_valid && r_s2_last_col && (r_s2_col != '0) && last_col_in);
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    assign last_col_in = ({1'b0, r_col} + (AW+1)'(1)) >= w_eff;
    assign last_row_in = ({1'b0, r_row} + (RW+1)'(1)) >= h_eff;

    // ---------------- line buffer ----------------
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_err          wr_data;
    t_err          ram_rdata;

    edd_ram #(
        .WIDTH (ERR_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ---------------- compute stage ----------------
    t_err mem_val;
    t_acc v_sum;
    logic white;
    t_acc err;
    t_acc s7;
    t_acc s3;
    t_acc s5;
    t_acc s1;
    t_err below_left;
    t_err pbl_next;
    t_err pb_next;
    t_err rc_next;
    t_err w1_data;
    t_err w2_data;

    always_comb begin
        // take the write from the cycle of the read when it hit the same entry
        mem_val    = r_fwd_hit ? r_fwd_data : ram_rdata;
        v_sum      = t_acc'(signed'({1'b0, r_s2_pixel, 4'b0000})) +
                     t_acc'(r_right_carry) + t_acc'(mem_val);
        white      = v_sum > THRESH;
        err        = white ? (v_sum - WHITE_LEVEL) : v_sum;
        s7         = rdiv16((err <<< 3) - err);
        s3         = rdiv16((err <<< 1) + err);
        s5         = rdiv16((err <<< 2) + err);
        s1         = rdiv16(err);
        below_left = sat16(t_acc'(r_pbl) + s3);
        pbl_next   = sat16(t_acc'(r_pb) + s5);
        pb_next    = sat16(s1);
        rc_next    = sat16(s7);
        // last row of the frame leaves zeros for the next frame
        w1_data    = r_s2_last_row ? t_err'(0) : below_left;
        w2_data    = r_s2_last_row ? t_err'(0) : pbl_next;
    end

    // Write port: clearing pass, then a deferred end-of-row write, then the
    // write of the item in the compute stage.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_s2_col;
        wr_data = w1_data;
        if (r_clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = t_err'(0);
        end else if (r_pend_valid) begin
            wr_en   = 1'b1;
            wr_addr = r_pend_addr;
            wr_data = r_pend_data;
        end else if (r_s2_valid && (r_s2_col != '0)) begin
            wr_en   = 1'b1;
            wr_addr = r_s2_col - AW'(1);
            wr_data = w1_data;
        end else if (r_s2_valid && r_s2_last_col) begin
            wr_en   = 1'b1;
            wr_addr = r_s2_col;
            wr_data = w2_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_s2_valid    <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_right_carry <= '0;
            r_pbl         <= '0;
            r_pb          <= '0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end

            // advance the raster position on each input transfer
            r_s2_valid <= in_acc;
            if (in_acc) begin
                if (last_col_in) begin
                    r_col <= '0;
                    r_row <= last_row_in ? '0 : (r_row + RW'(1));
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end

            // a last column that also wrote below-left defers its own entry
            r_pend_valid <= r_s2_valid && r_s2_last_col && (r_s2_col != '0);

            if (r_s2_valid) begin
                if (r_s2_last_col) begin
                    r_right_carry <= '0;
                    r_pbl         <= '0;
                    r_pb          <= '0;
                end else begin
                    r_right_carry <= rc_next;
                    r_pbl         <= pbl_next;
                    r_pb          <= pb_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s2_pixel    <= i_gray_pixel;
            r_s2_col      <= r_col;
            r_s2_last_col <= last_col_in;
            r_s2_last_row <= last_row_in;
        end
        r_fwd_hit   <= wr_en && (wr_addr == r_col);
        r_fwd_data  <= wr_data;
        r_pend_addr <= r_s2_col;
        r_pend_data <= w2_data;
    end

    // ---------------- output queue ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wr_ptr <= (r_wr_ptr == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0
                                                                    : r_wr_ptr + OUTQ_PW'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= (r_rd_ptr == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0
                                                                    : r_rd_ptr + OUTQ_PW'(1);
            end
            if (r_s2_valid && !out_acc) begin
                r_count <= r_count + OUTQ_PW'(1);
            end else if (!r_s2_valid && out_acc) begin
                r_count <= r_count - OUTQ_PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_q_white[r_wr_ptr] <= white;
            r_q_eor[r_wr_ptr]   <= r_s2_last_col;
        end
    end

    assign o_out_valid  = (r_count != '0);
    assign o_out_white  = r_q_white[r_rd_ptr];
    assign o_end_of_row = r_q_eor[r_rd_ptr];

    // ---------------- assertions ----------------
    a_pend_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !(r_s2_valid && ((r_s2_col != '0) || r_s2_last_col)))
        else $error("deferred write collides with another write");

    a_pend_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |=> !r_pend_valid)
        else $error("deferred write held more than one cycle");

    a_accept_computes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s2_valid)
        else $error("accepted pixel did not reach the compute stage");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> (r_count != OUTQ_PW'(OUTQ_DEPTH)) || out_acc)
        else $error("output queue overflow");

endmodule

// ----- src/edd_ram.sv -----
module edd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- tb/sv/error_diffusion_dither_unit_tb.sv -----
`timescale 1ns / 1ps

module error_diffusion_dither_unit_tb import edd_pkg::*;;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int N_PHASES      = 11;
    localparam int N_DIRECTED    = 26;

    typedef enum logic {ROW_PIXEL, ROW_GEOM} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [PIXEL_BITS-1:0] gray;
        logic [LW_BITS-1:0]    lw;
        logic [FH_BITS-1:0]    fh;
        logic                  typed;
        logic                  white;
        logic                  eor;
    } t_stim_row;

    typedef struct packed {
        logic white;
        logic eor;
    } t_dot;

    // Directed rows. Expected dots are typed in where they are obvious; the rest
    // come from the predictor.
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // reset geometry, first pixels of the frame
        '{ROW_PIXEL, 8'd255, 11'd0, 13'd0, 1'b1, 1'b1, 1'b0},
        '{ROW_PIXEL, 8'd0,   11'd0, 13'd0, 1'b1, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd128, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        // zero width and height act as one; column 3 is now past the row end
        '{ROW_GEOM,  8'd0,   11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd127, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd127, 11'd0, 13'd0, 1'b1, 1'b0, 1'b1},
        '{ROW_PIXEL, 8'd128, 11'd0, 13'd0, 1'b1, 1'b1, 1'b1},
        '{ROW_PIXEL, 8'd255, 11'd0, 13'd0, 1'b1, 1'b1, 1'b1},
        '{ROW_PIXEL, 8'd0,   11'd0, 13'd0, 1'b1, 1'b0, 1'b1},
        // all-ones registers clamp to the maximum size
        '{ROW_GEOM,  8'd0,   11'd2047, 13'd8191, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd200, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd60,  11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd255, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd0,   11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd129, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd126, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        // narrow two-row frames, width lowered mid-row
        '{ROW_GEOM,  8'd0,   11'd3, 13'd2, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd255, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd255, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd255, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd0,   11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd0,   11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd0,   11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd128, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd127, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, 8'd128, 11'd0, 13'd0, 1'b0, 1'b0, 1'b0}
    };

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    logic [PIXEL_BITS-1:0]    i_gray_pixel = '0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    logic                     o_out_white;
    logic                     o_end_of_row;
    logic                     i_cfg_we     = 1'b0;
    t_cfg_idx                 i_cfg_index  = CFG_LINE_WIDTH;
    logic [CFG_DATA_BITS-1:0] i_cfg_data   = '0;

    // predictor state: geometry registers, error line and running shares
    logic [LW_BITS-1:0] lw_reg;
    logic [FH_BITS-1:0] fh_reg;
    int                 line_err [MAX_W];
    int                 carry_right;
    int                 pend_below_left;
    int                 pend_below;
    int unsigned        col_pos;
    int unsigned        row_pos;

    t_dot dots_expected [$];
    int   err_count    = 0;
    bit   idle_on      = 1'b1;
    bit   hold_req     = 1'b0;
    bit   hold_done    = 1'b0;

    error_diffusion_dither_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_gray_pixel (i_gray_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_white  (o_out_white),
        .o_end_of_row (o_end_of_row),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp16(input int x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // divide by 16, round half up, without shifting negatives
    function automatic int div16_round(input int x);
        if (x >= 0) return (x + 8) / 16;
        return -((-x + 7) / 16);
    endfunction

    // Dither one pixel and advance the predictor's raster position and errors.
    function automatic t_dot dither_step(input logic [PIXEL_BITS-1:0] gray);
        int unsigned w, h, c;
        bit          last_col, last_row;
        int          work, qerr, s7, s3, s5, s1;
        t_dot        d;
        w = (lw_reg == 0) ? 1 : ((lw_reg > MAX_W) ? MAX_W : lw_reg);
        h = (fh_reg == 0) ? 1 : ((fh_reg > MAX_H) ? MAX_H : fh_reg);
        c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        last_col = (c + 1 >= w);
        last_row = (row_pos + 1 >= h);

        work    = int'(gray) * 16 + carry_right + line_err[c];
        d.white = (work > 127 * 16);
        d.eor   = last_col;
        qerr    = work - (d.white ? 255 * 16 : 0);

        s7 = div16_round(qerr * 7);
        s3 = div16_round(qerr * 3);
        s5 = div16_round(qerr * 5);
        s1 = div16_round(qerr);

        if (c > 0)
            line_err[c - 1] = last_row ? 0 : clamp16(pend_below_left + s3);
        pend_below_left = clamp16(pend_below + s5);
        pend_below      = clamp16(s1);
        carry_right     = clamp16(s7);

        if (last_col) begin
            // row end: flush this column, drop everything carried along the row
            line_err[c]     = last_row ? 0 : pend_below_left;
            pend_below_left = 0;
            pend_below      = 0;
            carry_right     = 0;
            col_pos         = 0;
            row_pos         = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
        return d;
    endfunction

    function automatic int gap_len();
        if (!idle_on || $urandom_range(0, 4) != 0) return 0;
        return $urandom_range(1, 19);
    endfunction

    // Offer one pixel, hold it until the transfer, then record its expected dot.
    // A nonzero idle drops valid afterwards; idle sets how long it stays low.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] gray, input bit typed,
                              input logic exp_white, input logic exp_eor, input int idle);
        t_dot d;
        i_in_valid   <= 1'b1;
        i_gray_pixel <= gray;
        do @(posedge i_clk); while (o_in_stall);
        d = dither_step(gray);
        if (typed) begin
            d.white = exp_white;
            d.eor   = exp_eor;
        end
        dots_expected.push_back(d);
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
    endtask

    task automatic drain_outputs();
        while (dots_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both geometry registers on back-to-back cycles; enable stays high.
    task automatic program_geometry(input logic [LW_BITS-1:0] lw,
                                    input logic [FH_BITS-1:0] fh);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LINE_WIDTH;
        i_cfg_data  <= CFG_DATA_BITS'(lw);
        @(posedge i_clk);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= fh;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lw_reg = lw;
        fh_reg = fh;
    endtask

    // output side: random stall bursts, plus one long hold-off to back up the block
    initial begin : out_side
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                // cut the burst short once idling is switched off
                for (int j = $urandom_range(1, 19); j > 0 && idle_on; j--)
                    @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // compare every output transfer with the oldest expected dot
    always @(posedge i_clk) begin
        t_dot want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (dots_expected.size() == 0) begin
                $display("%0t: unexpected output: expected none, got white=%0b eor=%0b",
                         $time, o_out_white, o_end_of_row);
                err_count++;
            end else begin
                want = dots_expected.pop_front();
                if (o_out_white !== want.white) begin
                    $display("%0t: out_white mismatch: expected %0b, got %0b",
                             $time, want.white, o_out_white);
                    err_count++;
                end
                if (o_end_of_row !== want.eor) begin
                    $display("%0t: end_of_row mismatch: expected %0b, got %0b",
                             $time, want.eor, o_end_of_row);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("error_diffusion_dither_unit_tb: errors");
        $finish;
    end

    initial begin : stimulus
        t_stim_row          r;
        bit                 last_here;
        logic [LW_BITS-1:0] lw;
        logic [FH_BITS-1:0] fh;
        int                 n;
        logic [7:0]         gray;

        lw_reg          = LW_RESET;
        fh_reg          = FH_RESET;
        carry_right     = 0;
        pend_below_left = 0;
        pend_below      = 0;
        col_pos         = 0;
        row_pos         = 0;
        foreach (line_err[k]) line_err[k] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        for (int i = 0; i < N_DIRECTED; i++) begin
            r = DIRECTED[i];
            if (r.kind == ROW_GEOM) begin
                drain_outputs();
                program_geometry(r.lw, r.fh);
            end else begin
                last_here = (i + 1 == N_DIRECTED) || (DIRECTED[i + 1].kind == ROW_GEOM);
                send_pixel(r.gray, r.typed, r.white, r.eor, last_here ? 1 : gap_len());
            end
        end

        // random phases; the first one leaves a long row half done so that the
        // next geometry cuts it short, and it carries the long output hold-off
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                lw = 11'd2047;
                fh = 13'd3;
                n  = 300;
            end else begin
                case ($urandom_range(0, 19)) inside
                    0:       lw = '0;
                    1:       lw = 11'd1024;
                    2:       lw = LW_BITS'($urandom_range(1025, 2047));
                    3:       lw = 11'd2047;
                    [4:11]:  lw = LW_BITS'($urandom_range(1, 16));
                    default: lw = LW_BITS'($urandom_range(17, 64));
                endcase
                case ($urandom_range(0, 19)) inside
                    0:       fh = '0;
                    1:       fh = 13'd4096;
                    2:       fh = FH_BITS'($urandom_range(4097, 8191));
                    3:       fh = 13'd8191;
                    [4:13]:  fh = FH_BITS'($urandom_range(1, 5));
                    default: fh = FH_BITS'($urandom_range(6, 40));
                endcase
                n = $urandom_range(60, 110);
            end
            drain_outputs();
            // no idling on either side in the closing phase
            idle_on = (p < N_PHASES - 1);
            program_geometry(lw, fh);
            if (p == 0) hold_req = 1'b1;
            for (int k = 0; k < n; k++) begin
                // bias toward the extremes and the threshold
                case ($urandom_range(0, 9))
                    0:       gray = 8'd0;
                    1:       gray = 8'd255;
                    2:       gray = 8'($urandom_range(120, 135));
                    default: gray = 8'($urandom_range(0, 255));
                endcase
                send_pixel(gray, 1'b0, 1'b0, 1'b0, (k == n - 1) ? 1 : gap_len());
            end
        end

        drain_outputs();
        if (err_count == 0) begin
            $display("error_diffusion_dither_unit_tb: clean");
        end else begin
            $display("error_diffusion_dither_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/edd_pkg.sv
src/edd_ram.sv
src/error_diffusion_dither_unit.sv
tb/sv/error_diffusion_dither_unit_tb.sv
